/* hw/rtl/stc_pkg.sv */
`default_nettype none

package stc_pkg;

   // register map
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SCALE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_NUMER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_DENOM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_VALID = 3'd4;

   // divider geometry: |numer| << 11 is at most 2^26, |X1 + denom| stays below 2^18
   localparam int unsigned DIV_STEPS = 27;
   localparam int unsigned DVSR_W    = 18;

   // tenths of a degree whose truncated tenth lands on -40 and 120
   localparam logic signed [24:0] T_LO = -25'sd409;
   localparam logic signed [24:0] T_HI = 25'sd1209;

   // m / 10 == (m * 6554) >> 16 for m below 16384
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_CAL   = 2'd1,
      STATUS_ZERO_DIV = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [17:0] x1;
      logic               qneg;
      status_type         status;
   } stc_side_type;

   typedef struct packed {
      logic [DVSR_W-1:0]    rem;
      logic [DIV_STEPS-1:0] dq;
      logic [DVSR_W-1:0]    dvsr;
   } stc_div_type;

endpackage

`default_nettype wire

/* hw/rtl/stc_req_if.sv */
`default_nettype none

interface stc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temperature;

   modport source (output valid, output raw_temperature, input ready);
   modport sink   (input valid, input raw_temperature, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stc_rsp_if.sv */
`default_nettype none

interface stc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] temperature_c;
   logic [1:0]        status;

   modport source (output valid, output temperature_c, output status, input ready);
   modport sink   (input valid, input temperature_c, input status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stc_csr_if.sv */
`default_nettype none

interface stc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sensor_temp_compensation_unit.sv */
// channel   dir  payload                                  taken when
// req_bus   in   raw_temperature[15:0]                    valid & ready
// rsp_bus   out  temperature_c[7:0] s, status[1:0]         valid & ready
// csr_bus   in   index[2:0], data[15:0]                   valid & ready (ready held high)
//
// One word enters per cycle while the output is not stalled; each result passes
// through 2 front stages, 27 divider cells and 2 back stages.
// The divider is a row of 27 restoring cells, one quotient bit each.
// Synchronous reset clears all valid bits and the calibration registers.
// A stalled result freezes the whole pipe; req_bus.ready follows that freeze.
`default_nettype none

module sensor_temp_compensation_unit import stc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   stc_req_if.sink   req_bus,
   stc_rsp_if.source rsp_bus,
   stc_csr_if.sink   csr_bus
);

   logic [15:0]        coef_scale_ff;
   logic [15:0]        coef_offset_ff;
   logic signed [15:0] coef_numer_ff;
   logic signed [15:0] coef_denom_ff;
   logic               calib_valid_ff;

   logic               adv;

   logic               cell_valid [DIV_STEPS+1];
   stc_side_type       cell_side  [DIV_STEPS+1];
   stc_div_type        cell_div   [DIV_STEPS+1];

   logic               back_valid;
   logic signed [7:0]  back_temp;
   status_type         back_status;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_scale_ff  <= '0;
         coef_offset_ff <= '0;
         coef_numer_ff  <= '0;
         coef_denom_ff  <= '0;
         calib_valid_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_COEF_SCALE:  coef_scale_ff  <= csr_bus.data;
            CSR_COEF_OFFSET: coef_offset_ff <= csr_bus.data;
            CSR_COEF_NUMER:  coef_numer_ff  <= csr_bus.data;
            CSR_COEF_DENOM:  coef_denom_ff  <= csr_bus.data;
            CSR_CALIB_VALID: calib_valid_ff <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // whole pipe moves unless the output word is held
   assign adv           = !back_valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   stc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (req_bus.valid),
      .raw_temperature (req_bus.raw_temperature),
      .coef_scale      (coef_scale_ff),
      .coef_offset     (coef_offset_ff),
      .coef_numer      (coef_numer_ff),
      .coef_denom      (coef_denom_ff),
      .calib_valid     (calib_valid_ff),
      .out_valid       (cell_valid[0]),
      .out_side        (cell_side[0]),
      .out_div         (cell_div[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      stc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (cell_valid[i]),
         .in_side   (cell_side[i]),
         .in_div    (cell_div[i]),
         .out_valid (cell_valid[i+1]),
         .out_side  (cell_side[i+1]),
         .out_div   (cell_div[i+1])
      );
   end

   stc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (cell_valid[DIV_STEPS]),
      .in_side       (cell_side[DIV_STEPS]),
      .quotient      (cell_div[DIV_STEPS].dq),
      .out_valid     (back_valid),
      .temperature_c (back_temp),
      .status        (back_status)
   );

   assign rsp_bus.valid         = back_valid;
   assign rsp_bus.temperature_c = back_temp;
   assign rsp_bus.status        = back_status;

endmodule

`default_nettype wire

/* hw/rtl/stc_front.sv */
`default_nettype none

module stc_front import stc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic [15:0]        raw_temperature,
   input  wire logic [15:0]        coef_scale,
   input  wire logic [15:0]        coef_offset,
   input  wire logic signed [15:0] coef_numer,
   input  wire logic signed [15:0] coef_denom,
   input  wire logic               calib_valid,
   output logic                    out_valid,
   output stc_side_type            out_side,
   output stc_div_type             out_div
);

   logic               a_valid_ff, a_valid_in;
   logic signed [32:0] a_prod_ff, a_prod_in;
   logic signed [16:0] diff;

   logic               b_valid_ff, b_valid_in;
   stc_side_type       b_side_ff, b_side_in;
   stc_div_type        b_div_ff, b_div_in;

   logic signed [17:0] x1;
   logic signed [18:0] dsum;
   logic [15:0]        numer_mag;

   // stage A: (raw - offset) * scale
   always_comb begin
      diff       = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef_offset});
      a_prod_in  = diff * $signed({1'b0, coef_scale});
      a_valid_in = in_valid;
   end

   // stage B: X1, divisor, operand magnitudes and status
   always_comb begin
      x1        = a_prod_ff[32:15];
      dsum      = {x1[17], x1} + {{3{coef_denom[15]}}, coef_denom};
      numer_mag = coef_numer[15] ? 16'(-coef_numer) : coef_numer;

      b_side_in.x1   = x1;
      b_side_in.qneg = coef_numer[15] ^ dsum[18];
      priority if (!calib_valid) begin
         b_side_in.status = STATUS_NO_CAL;
      end else if (dsum == '0) begin
         b_side_in.status = STATUS_ZERO_DIV;
      end else begin
         b_side_in.status = STATUS_OK;
      end

      b_div_in.rem  = '0;
      b_div_in.dq   = {numer_mag, 11'b0};
      b_div_in.dvsr = dsum[18] ? DVSR_W'(-dsum) : dsum[DVSR_W-1:0];
      b_valid_in    = a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff <= a_prod_in;
         b_side_ff <= b_side_in;
         b_div_ff  <= b_div_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_side  = b_side_ff;
   assign out_div   = b_div_ff;

endmodule

`default_nettype wire

/* hw/rtl/stc_div_cell.sv */
`default_nettype none

// one restoring-division step: one quotient bit shifted in per cell
module stc_div_cell import stc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire stc_side_type  in_side,
   input  wire stc_div_type   in_div,
   output logic               out_valid,
   output stc_side_type       out_side,
   output stc_div_type        out_div
);

   logic              valid_ff;
   stc_side_type      side_ff;
   stc_div_type       div_ff, div_in;

   logic [DVSR_W:0]   rem_sh;
   logic [DVSR_W+1:0] trial;
   logic              take;

   always_comb begin
      rem_sh = {in_div.rem, in_div.dq[DIV_STEPS-1]};
      trial  = {1'b0, rem_sh} - {2'b0, in_div.dvsr};
      take   = !trial[DVSR_W+1];

      div_in.rem  = take ? trial[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
      div_in.dq   = {in_div.dq[DIV_STEPS-2:0], take};
      div_in.dvsr = in_div.dvsr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= in_side;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_div   = div_ff;

endmodule

`default_nettype wire

/* hw/rtl/stc_back.sv */
`default_nettype none

module stc_back import stc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire stc_side_type       in_side,
   input  wire logic [DIV_STEPS-1:0] quotient,
   output logic                    out_valid,
   output logic signed [7:0]       temperature_c,
   output status_type              status
);

   logic               c_valid_ff, c_valid_in;
   logic signed [11:0] c_t_ff, c_t_in;
   status_type         c_status_ff;

   logic               d_valid_ff;
   logic signed [7:0]  d_temp_ff, d_temp_in;
   status_type         d_status_ff;

   logic signed [27:0] x2;
   logic signed [28:0] tsum;
   logic signed [24:0] t;

   logic               neg;
   logic [10:0]        mag;
   logic [23:0]        prod;
   logic [6:0]         q;

   // stage C: sign the quotient, T = (X1 + X2 + 8) >> 4, clamp in tenths
   always_comb begin
      x2   = in_side.qneg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
      tsum = {{11{in_side.x1[17]}}, in_side.x1} + {x2[27], x2} + 29'sd8;
      t    = tsum[28:4];
      priority if (t < T_LO) begin
         c_t_in = T_LO[11:0];
      end else if (t > T_HI) begin
         c_t_in = T_HI[11:0];
      end else begin
         c_t_in = t[11:0];
      end
      c_valid_in = in_valid;
   end

   // stage D: truncating divide by ten on the magnitude; zero when status is not OK
   always_comb begin
      neg  = c_t_ff[11];
      mag  = neg ? 11'(-c_t_ff) : c_t_ff[10:0];
      prod = 24'(mag) * 24'(RECIP_TEN);
      q    = prod[22:16];
      if (c_status_ff != STATUS_OK) begin
         d_temp_in = '0;
      end else if (neg) begin
         d_temp_in = -$signed({1'b0, q});
      end else begin
         d_temp_in = $signed({1'b0, q});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_t_ff      <= c_t_in;
         c_status_ff <= in_side.status;
         d_temp_ff   <= d_temp_in;
         d_status_ff <= c_status_ff;
      end
   end

   assign out_valid     = d_valid_ff;
   assign temperature_c = d_temp_ff;
   assign status        = d_status_ff;

endmodule

`default_nettype wire

/* verif/stc_checker.sv */
`default_nettype none

module stc_checker import stc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   stc_req_if        req_mon,
   stc_rsp_if        rsp_mon,
   stc_csr_if        csr_mon,
   output int        fail_count,
   output int        pending_count,
   output int        ok_count,
   output int        no_cal_count,
   output int        zero_div_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TEMP_MIN = -40;
   localparam longint TEMP_MAX = 120;

   typedef struct packed {
      logic signed [7:0] temperature_c;
      status_type        status;
   } compensated_reading_type;

   // local copy of the calibration words
   logic [15:0]        cal_scale;
   logic [15:0]        cal_offset;
   logic signed [15:0] cal_numer;
   logic signed [15:0] cal_denom;
   logic               cal_valid;

   compensated_reading_type expected_readings[$];
   compensated_reading_type want;

   function automatic compensated_reading_type predict_reading(input logic [15:0] raw);
      compensated_reading_type r;
      longint x1, dvsr, x2, tenths, whole;
      r.temperature_c = '0;
      if (!cal_valid) begin
         r.status = STATUS_NO_CAL;
         return r;
      end
      // arithmetic shift on a signed value floors, as the scaling needs
      x1 = ((longint'(raw) - longint'(cal_offset)) * longint'(cal_scale)) >>> 15;
      dvsr = x1 + longint'(cal_denom);
      if (dvsr == 0) begin
         r.status = STATUS_ZERO_DIV;
         return r;
      end
      // quotient and the divide by ten both truncate toward zero
      x2 = (longint'(cal_numer) * 2048) / dvsr;
      tenths = (x1 + x2 + 8) >>> 4;
      whole = tenths / 10;
      if (whole < TEMP_MIN) whole = TEMP_MIN;
      else if (whole > TEMP_MAX) whole = TEMP_MAX;
      r.temperature_c = whole[7:0];
      r.status = STATUS_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cal_scale      = '0;
         cal_offset     = '0;
         cal_numer      = '0;
         cal_denom      = '0;
         cal_valid      = 1'b0;
         fail_count     = 0;
         ok_count       = 0;
         no_cal_count   = 0;
         zero_div_count = 0;
         expected_readings.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_COEF_SCALE:  cal_scale  = csr_mon.data;
               CSR_COEF_OFFSET: cal_offset = csr_mon.data;
               CSR_COEF_NUMER:  cal_numer  = csr_mon.data;
               CSR_COEF_DENOM:  cal_denom  = csr_mon.data;
               CSR_CALIB_VALID: cal_valid  = csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_readings.push_back(predict_reading(req_mon.raw_temperature));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected word: temperature_c %0d status %0d",
                      rsp_mon.temperature_c, rsp_mon.status);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_mon.temperature_c !== want.temperature_c) begin
                  $error("temperature_c mismatch: expected %0d, actual %0d",
                         want.temperature_c, rsp_mon.temperature_c);
                  fail_count++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  fail_count++;
               end
               case (want.status)
                  STATUS_OK:       ok_count++;
                  STATUS_NO_CAL:   no_cal_count++;
                  STATUS_ZERO_DIV: zero_div_count++;
                  default: ;
               endcase
            end
         end
      end
      pending_count = expected_readings.size();
   end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import stc_pkg::*;

   localparam int NUM_SEGMENTS      = 29;
   localparam int WORDS_PER_SEGMENT = 50;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int DRAIN_CYCLES      = 40;

   logic clock;
   logic reset;

   int src_idle_pct  = 28;
   int sink_idle_pct = 59;
   int cycle_count   = 0;
   int settings_used = 0;

   int fail_count, pending_count, ok_count, no_cal_count, zero_div_count;

   // what the stimulus knows of the current calibration
   logic [15:0]        cur_offset;
   logic signed [15:0] cur_denom;

   stc_req_if req_bus();
   stc_rsp_if rsp_bus();
   stc_csr_if csr_bus();

   sensor_temp_compensation_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   stc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .ok_count       (ok_count),
      .no_cal_count   (no_cal_count),
      .zero_div_count (zero_div_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d words outstanding", cycle_count, pending_count);
         $display("FAIL sensor_temp_compensation_unit");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] index, input logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // only while the pipe is empty
   task automatic program_calibration(input logic [15:0] scale, input logic [15:0] offset,
                                      input logic [15:0] numer, input logic [15:0] denom,
                                      input logic [15:0] valid_word);
      wait_drained();
      csr_write(CSR_COEF_SCALE, scale);
      csr_write(CSR_COEF_OFFSET, offset);
      // out-of-range index must leave every register alone
      csr_write(CSR_CALIB_VALID + 3'(1 + $urandom_range(0, 2)), 16'($urandom));
      csr_write(CSR_COEF_NUMER, numer);
      csr_write(CSR_COEF_DENOM, denom);
      csr_write(CSR_CALIB_VALID, valid_word);
      csr_bus.valid <= 1'b0;
      cur_offset = offset;
      cur_denom  = denom;
      settings_used++;
   endtask

   task automatic send_raw(input logic [15:0] raw);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.raw_temperature <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_raw();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($urandom_range(0, 65535));
         4, 5, 6, 7: v = int'(cur_offset) + int'($urandom_range(0, 12000)) - 6000;
         8:          v = $urandom_range(0, 1) ? 65535 : 0;
         // with unit scale this lands the divisor on zero
         default:    v = int'(cur_offset) - int'(cur_denom);
      endcase
      if (v < 0 || v > 65535) v = int'($urandom_range(0, 65535));
      return 16'(v);
   endfunction

   task automatic program_random_calibration();
      logic [15:0] valid_word;
      valid_word = 16'($urandom) | 16'h0001;
      case ($urandom_range(0, 5))
         0: program_calibration(pick_word(), pick_word(), pick_word(), pick_word(),
                                valid_word);
         1, 2: program_calibration(16'($urandom_range(20000, 32767)),
                                   16'($urandom_range(15000, 30000)),
                                   16'(-int'($urandom_range(4000, 16000))),
                                   16'($urandom_range(1000, 4000)), valid_word);
         3, 4: program_calibration(16'h8000, 16'($urandom), pick_word(),
                                   16'(int'($urandom_range(0, 4000)) - 2000), valid_word);
         default: program_calibration(pick_word(), pick_word(), pick_word(), pick_word(),
                                      16'($urandom) & 16'hFFFE);
      endcase
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.raw_temperature = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.index           = '0;
      csr_bus.data            = '0;
      cur_offset              = '0;
      cur_denom               = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers straight out of reset: uncalibrated
      send_raw(16'h0000);
      send_raw(16'hFFFF);

      // valid word with bit 0 clear and upper bits set stays uncalibrated
      program_calibration(16'h8000, 16'd100, 16'h0000, 16'h0000, 16'hFFFE);
      send_raw(16'd1234);

      // unit scale: zero divisor, top clamp, negative tenths truncating to zero
      program_calibration(16'h8000, 16'd100, 16'h0000, 16'h0000, 16'h0001);
      send_raw(16'd100);
      send_raw(16'hFFFF);
      send_raw(16'd0);
      send_raw(16'd80);
      send_raw(16'd101);

      program_calibration(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_raw(16'd0);
      send_raw(16'hFFFF);
      send_raw(16'h8000);

      program_calibration(16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001);
      send_raw(16'd0);
      send_raw(16'hFFFF);

      program_calibration(16'd25000, 16'd20000, 16'(-11000), 16'd2500, 16'h0001);
      send_raw(16'd26000);
      send_raw(16'd20000);
      send_raw(16'd14000);
      send_raw(16'd30000);

      // divisor of zero and of one either side of it
      program_calibration(16'h8000, 16'd40000, 16'd5000, 16'(-100), 16'h0001);
      send_raw(16'd40100);
      send_raw(16'd40101);
      send_raw(16'd40099);

      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         if (seg == 10) begin
            src_idle_pct  = 59;
            sink_idle_pct = 28;
         end else if (seg == 20) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         program_random_calibration();
         for (int n = 0; n < WORDS_PER_SEGMENT; n++) send_raw(pick_raw());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d compensated readings over %0d calibration settings.",
               ok_count + no_cal_count + zero_div_count, settings_used);
      $display("Status mix: %0d ok, %0d uncalibrated, %0d zero divisor; %0d failures.",
               ok_count, no_cal_count, zero_div_count, fail_count);
      if (fail_count == 0) begin
         $display("PASS sensor_temp_compensation_unit");
      end else begin
         $display("FAIL sensor_temp_compensation_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/stc_pkg.sv
hw/rtl/stc_req_if.sv
hw/rtl/stc_rsp_if.sv
hw/rtl/stc_csr_if.sv
hw/rtl/stc_front.sv
hw/rtl/stc_div_cell.sv
hw/rtl/stc_back.sv
hw/rtl/sensor_temp_compensation_unit.sv
verif/stc_checker.sv
verif/tb_top.sv
